// ----- rtl/srbb_pkg.sv -----
package srbb_pkg;

  localparam int COST_W    = 24;
  localparam int CITY_W    = 4;
  localparam int CNUM_W    = 5;
  localparam int NCITY_W   = 5;
  localparam int DIST_IN_W = 16;

  localparam logic [COST_W-1:0]  COST_ONES      = {COST_W{1'b1}};
  localparam logic [NCITY_W-1:0] NUM_CITIES_RST = 5'd13;
  localparam logic [CITY_W-1:0]  START_CITY_RST = 4'd9;

  localparam logic REG_NUM_CITIES = 1'b0;
  localparam logic REG_START_CITY = 1'b1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

endpackage

// ----- rtl/shortest_route_branch_bound.sv -----
// Shortest open route search by depth-first branch and bound. A load word (action 0)
// writes a distance and its mirror into the table RAM, one write per state (S_IDLE, then
// S_LOAD) on the single write port. A run word (action 1) searches all open paths from
// start_city over num_cities cities, trying candidates in ascending order and pruning any
// partial cost not strictly below the best so far; the first cheapest route is kept. Each
// branch tried passes S_SCAN (free-city pick plus table read), then S_ADD (saturating add
// and compare in the single adder); each complete route or backtrack takes S_SCAN alone, so
// the search time is data dependent and set by the size of the pruned search tree. The
// route then leaves as one result word per city (one-based numbers), one per cycle while
// out_ready holds, or a single word with all-ones cost and city 0 when no route exists. The
// table is undefined until written; every entry a search reads must have been loaded.
module shortest_route_branch_bound
  import srbb_pkg::*;
#(
  parameter int MAX_NODES = 16,
  parameter int DIST_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [CITY_W-1:0]    in_row_city,
  input  logic [CITY_W-1:0]    in_col_city,
  input  logic [DIST_IN_W-1:0] in_distance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COST_W-1:0]    out_best_cost,
  output logic [CITY_W-1:0]    out_position,
  output logic [CNUM_W-1:0]    out_city_number,
  output logic                 out_last,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int NCAP  = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam int LVL_W = $clog2(NCAP + 1);
  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int AW    = $clog2(MAX_NODES * MAX_NODES);
  localparam int SUM_W = ((DIST_BITS > COST_W) ? DIST_BITS : COST_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]           state_r;
  logic [NCITY_W-1:0]   num_cities_r;
  logic [CITY_W-1:0]    start_city_r;

  logic [CITY_W-1:0]    ld_row_r;
  logic [CITY_W-1:0]    ld_col_r;
  logic [DIST_BITS-1:0] ld_dist_r;

  logic [IDX_W-1:0]     route_stk_r [MAX_NODES];
  logic [COST_W-1:0]    cost_r      [MAX_NODES];
  logic [LVL_W-1:0]     next_cand_r [MAX_NODES];
  logic [IDX_W-1:0]     best_route_r [MAX_NODES];
  logic [NCAP-1:0]      visited_r;
  logic [LVL_W-1:0]     lvl_r;
  logic [LVL_W-1:0]     n_r;
  logic [COST_W-1:0]    best_r;
  logic [IDX_W-1:0]     cand_r;
  logic [LVL_W-1:0]     pos_r;

  logic                 out_valid_r;
  logic [COST_W-1:0]    out_best_cost_r;
  logic [CITY_W-1:0]    out_position_r;
  logic [CNUM_W-1:0]    out_city_number_r;
  logic                 out_last_r;

  logic                 in_acc;
  logic                 ld_in_range;
  logic [LVL_W-1:0]     n_run;
  logic [LVL_W-1:0]     lvm1;
  logic [LVL_W-1:0]     lvp1;
  logic [IDX_W-1:0]     lvl_idx;
  logic [IDX_W-1:0]     lvm1_idx;
  logic [IDX_W-1:0]     lvp1_idx;
  logic [IDX_W-1:0]     pos_idx;
  logic [IDX_W-1:0]     prev_city;
  logic                 fnd;
  logic [IDX_W-1:0]     fnd_city;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [DIST_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [DIST_BITS-1:0] ram_rdata;
  logic [SUM_W-1:0]     sum;
  logic [COST_W-1:0]    sum_sat;
  logic                 emit_last;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign pready   = 1'b1;

  assign ld_in_range = (int'(in_row_city) < MAX_NODES) && (int'(in_col_city) < MAX_NODES);

  always_comb begin
    if (num_cities_r == '0) begin
      n_run = LVL_W'(1);
    end else if (int'(num_cities_r) > NCAP) begin
      n_run = LVL_W'(NCAP);
    end else begin
      n_run = LVL_W'(num_cities_r);
    end
  end

  assign lvm1      = lvl_r - LVL_W'(1);
  assign lvp1      = lvl_r + LVL_W'(1);
  assign lvl_idx   = lvl_r[IDX_W-1:0];
  assign lvm1_idx  = lvm1[IDX_W-1:0];
  assign lvp1_idx  = lvp1[IDX_W-1:0];
  assign pos_idx   = pos_r[IDX_W-1:0];
  assign prev_city = route_stk_r[lvm1_idx];
  assign emit_last = ((pos_r + LVL_W'(1)) == n_r);

  srbb_find #(
    .NCAP  (NCAP),
    .LVL_W (LVL_W),
    .IDX_W (IDX_W)
  ) u_find (
    .visited (visited_r),
    .first   (next_cand_r[lvl_idx]),
    .count   (n_r),
    .found   (fnd),
    .city    (fnd_city)
  );

  always_comb begin
    if (state_r == S_LOAD) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(ld_col_r) * AW'(MAX_NODES) + AW'(ld_row_r);
      ram_wdata = ld_dist_r;
    end else begin
      ram_we    = in_acc && (in_action == ACT_LOAD) && ld_in_range;
      ram_waddr = AW'(in_row_city) * AW'(MAX_NODES) + AW'(in_col_city);
      ram_wdata = DIST_BITS'(in_distance);
    end
    ram_raddr = AW'(fnd_city) * AW'(MAX_NODES) + AW'(prev_city);
  end

  srbb_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (MAX_NODES * MAX_NODES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sum = SUM_W'(cost_r[lvm1_idx]) + SUM_W'(ram_rdata);
    if (sum > SUM_W'(COST_ONES)) begin
      sum_sat = COST_ONES;
    end else begin
      sum_sat = sum[COST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cities_r <= NUM_CITIES_RST;
      start_city_r <= START_CITY_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_NUM_CITIES: num_cities_r <= pwdata[NCITY_W-1:0];
        REG_START_CITY: start_city_r <= pwdata[CITY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NUM_CITIES: prdata = 32'(num_cities_r);
      REG_START_CITY: prdata = 32'(start_city_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_action == ACT_LOAD) begin
              if (ld_in_range) begin
                ld_row_r  <= in_row_city;
                ld_col_r  <= in_col_city;
                ld_dist_r <= DIST_BITS'(in_distance);
                state_r   <= S_LOAD;
              end
            end else begin
              n_r    <= n_run;
              best_r <= COST_ONES;
              pos_r  <= '0;
              if (int'(start_city_r) < int'(n_run)) begin
                route_stk_r[0] <= IDX_W'(start_city_r);
                cost_r[0]      <= '0;
                visited_r      <= NCAP'(1) << start_city_r;
                lvl_r          <= LVL_W'(1);
                next_cand_r[1] <= '0;
                state_r        <= S_SCAN;
              end else begin
                state_r <= S_EMIT;
              end
            end
          end
        end
        S_LOAD: begin
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          if (lvl_r == '0) begin
            state_r <= S_EMIT;
          end else if (lvl_r >= n_r) begin
            if (cost_r[lvm1_idx] < best_r) begin
              best_r       <= cost_r[lvm1_idx];
              best_route_r <= route_stk_r;
            end
            lvl_r <= lvm1;
            if (lvm1 != '0) begin
              visited_r <= visited_r & ~(NCAP'(1) << route_stk_r[lvm1_idx]);
            end
          end else if (fnd) begin
            next_cand_r[lvl_idx] <= LVL_W'(fnd_city) + LVL_W'(1);
            cand_r               <= fnd_city;
            state_r              <= S_ADD;
          end else begin
            lvl_r <= lvm1;
            if (lvm1 != '0) begin
              visited_r <= visited_r & ~(NCAP'(1) << route_stk_r[lvm1_idx]);
            end
          end
        end
        S_ADD: begin
          if (sum_sat < best_r) begin
            route_stk_r[lvl_idx] <= cand_r;
            cost_r[lvl_idx]      <= sum_sat;
            visited_r            <= visited_r | (NCAP'(1) << cand_r);
            lvl_r                <= lvp1;
            if (lvp1 < n_r) begin
              next_cand_r[lvp1_idx] <= '0;
            end
          end
          state_r <= S_SCAN;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r     <= 1'b1;
            out_best_cost_r <= best_r;
            if (best_r == COST_ONES) begin
              out_position_r    <= '0;
              out_city_number_r <= '0;
              out_last_r        <= 1'b1;
              state_r           <= S_IDLE;
            end else begin
              out_position_r    <= CITY_W'(pos_r);
              out_city_number_r <= CNUM_W'(best_route_r[pos_idx]) + CNUM_W'(1);
              out_last_r        <= emit_last;
              pos_r             <= pos_r + LVL_W'(1);
              if (emit_last) begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_best_cost   = out_best_cost_r;
  assign out_position    = out_position_r;
  assign out_city_number = out_city_number_r;
  assign out_last        = out_last_r;

endmodule

// ----- rtl/srbb_ram.sv -----
module srbb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/srbb_find.sv -----
module srbb_find #(
  parameter int NCAP  = 16,
  parameter int LVL_W = 5,
  parameter int IDX_W = 4
) (
  input  logic [NCAP-1:0]  visited,
  input  logic [LVL_W-1:0] first,
  input  logic [LVL_W-1:0] count,
  output logic             found,
  output logic [IDX_W-1:0] city
);

  // lowest unvisited city at or above first and below count
  always_comb begin
    found = 1'b0;
    city  = '0;
    for (int j = NCAP - 1; j >= 0; j--) begin
      if (!visited[j] && (LVL_W'(j) >= first) && (LVL_W'(j) < count)) begin
        found = 1'b1;
        city  = IDX_W'(j);
      end
    end
  end

endmodule

// ----- rtl/srbb_checker.sv -----
module srbb_checker
  import srbb_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [COST_W-1:0] out_best_cost,
  input logic [CITY_W-1:0] out_position,
  input logic [CNUM_W-1:0] out_city_number,
  input logic              out_last
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_cost) &&
      $stable(out_position) && $stable(out_city_number) && $stable(out_last))
    else $error("output word changed while stalled");

  // no new input while a route is still going out
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input accepted during route output");

  // route words follow back to back
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_position == 4'($past(out_position) + 4'd1)))
    else $error("route position did not advance");

  a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_best_cost == COST_ONES) |->
      out_last && (out_position == '0) && (out_city_number == '0))
    else $error("bad no-route word");

  a_city_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_best_cost != COST_ONES) |-> (out_city_number != '0))
    else $error("zero city number on found route");

endmodule

bind shortest_route_branch_bound srbb_checker u_srbb_checker (.*);

// ----- tb/shortest_route_branch_bound_check.sv -----
`timescale 1ns / 1ps
module shortest_route_branch_bound_check
  import srbb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_action,
  input  logic [CITY_W-1:0]    in_row_city,
  input  logic [CITY_W-1:0]    in_col_city,
  input  logic [DIST_IN_W-1:0] in_distance,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [COST_W-1:0]    out_best_cost,
  input  logic [CITY_W-1:0]    out_position,
  input  logic [CNUM_W-1:0]    out_city_number,
  input  logic                 out_last,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output int                   stops_due,
  output int                   bad_words
);

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [CITY_W-1:0] pos;
    logic [CNUM_W-1:0] city;
    logic              last;
  } stop_t;

  stop_t                route_due[$];
  logic [DIST_IN_W-1:0] road_len[16][16];
  logic [NCITY_W-1:0]   ncity_cfg;
  logic [CITY_W-1:0]    origin_cfg;
  int                   bad_seen = 0;

  function automatic void note_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      bad_seen++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // depth-first branch and bound, ascending candidates, strict-improvement pruning
  task automatic find_best_route();
    int                n;
    int                lvl;
    int                c;
    logic [CITY_W-1:0] tour[16];
    logic [CITY_W-1:0] best_tour[16];
    logic [COST_W-1:0] part_cost[16];
    int                next_try[17];
    logic [15:0]       used;
    logic [COST_W-1:0] best;
    logic [COST_W:0]   sum;
    n = ncity_cfg;
    if (n > 16) n = 16;
    if (n == 0) n = 1;
    best = COST_ONES;
    if (origin_cfg < n) begin
      tour[0] = origin_cfg;
      part_cost[0] = '0;
      used = 16'd1 << origin_cfg;
      lvl = 1;
      next_try[1] = 0;
      while (lvl >= 1) begin
        if (lvl >= n) begin
          if (part_cost[n-1] < best) begin
            best = part_cost[n-1];
            best_tour = tour;
          end
          lvl--;
          if (lvl >= 1) used[tour[lvl]] = 1'b0;
        end else begin
          c = next_try[lvl];
          while (c < n && used[c]) c++;
          if (c >= n) begin
            lvl--;
            if (lvl >= 1) used[tour[lvl]] = 1'b0;
          end else begin
            next_try[lvl] = c + 1;
            sum = part_cost[lvl-1] + road_len[c][tour[lvl-1]];
            if (sum > COST_ONES) sum = COST_ONES;
            if (sum[COST_W-1:0] < best) begin
              tour[lvl] = CITY_W'(c);
              part_cost[lvl] = sum[COST_W-1:0];
              used[c] = 1'b1;
              lvl++;
              if (lvl < n) next_try[lvl] = 0;
            end
          end
        end
      end
    end
    if (best == COST_ONES) begin
      route_due.push_back({COST_ONES, 4'd0, 5'd0, 1'b1});
    end else begin
      for (int i = 0; i < n; i++)
        route_due.push_back({best, 4'(i), 5'(best_tour[i]) + 5'd1, i == n - 1});
    end
  endtask

  always @(posedge clk) begin
    stop_t want;
    if (!rst_n) begin
      ncity_cfg = NUM_CITIES_RST;
      origin_cfg = START_CITY_RST;
      route_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (route_due.size() == 0) begin
          bad_seen++;
          $error("route word with none due: best_cost %0d city_number %0d",
                 out_best_cost, out_city_number);
        end else begin
          want = route_due.pop_front();
          note_field("best_cost", want.cost, out_best_cost);
          note_field("position", want.pos, out_position);
          note_field("city_number", want.city, out_city_number);
          note_field("last", want.last, out_last);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_NUM_CITIES, 2'b00}) ncity_cfg = pwdata[NCITY_W-1:0];
        else if (paddr == {REG_START_CITY, 2'b00}) origin_cfg = pwdata[CITY_W-1:0];
      end
      if (in_valid && in_ready) begin
        if (in_action == ACT_LOAD) begin
          road_len[in_row_city][in_col_city] = in_distance;
          road_len[in_col_city][in_row_city] = in_distance;
        end else begin
          find_best_route();
        end
      end
    end
    stops_due <= route_due.size();
    bad_words <= bad_seen;
  end

endmodule

// ----- tb/shortest_route_branch_bound_tb.sv -----
`timescale 1ns / 1ps
module shortest_route_branch_bound_tb;
  import srbb_pkg::*;

  localparam int IDLE_LIMIT = 100000;
  localparam int SETTLE = 8;
  localparam int RANDOM_WORDS = 55;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_action = ACT_LOAD;
  logic [CITY_W-1:0]    in_row_city = '0;
  logic [CITY_W-1:0]    in_col_city = '0;
  logic [DIST_IN_W-1:0] in_distance = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COST_W-1:0]    out_best_cost;
  logic [CITY_W-1:0]    out_position;
  logic [CNUM_W-1:0]    out_city_number;
  logic                 out_last;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  int                   stops_due;
  int                   bad_words;

  logic [15:0] map_len[16][16];
  int          words_sent = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  int          stall_left = 0;

  always #10 clk = ~clk;

  shortest_route_branch_bound dut (.*);
  shortest_route_branch_bound_check route_check (.*);

  // result side back-pressure
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm_out <= !calm_out;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm_out && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("shortest_route_branch_bound_tb: done, errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm_in) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input logic act, input logic [3:0] r, input logic [3:0] c,
                           input logic [15:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_row_city <= r;
    in_col_city <= c;
    in_distance <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic load_dist(input int r, input int c, input logic [15:0] d);
    send_word(ACT_LOAD, CITY_W'(r), CITY_W'(c), d);
    map_len[r][c] = d;
    map_len[c][r] = d;
  endtask

  task automatic run_search();
    send_word(ACT_RUN, CITY_W'($urandom_range(0, 15)), CITY_W'($urandom_range(0, 15)),
              16'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (stops_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_cfg(input int ncity, input int origin);
    logic [31:0] w;
    wait_idle();
    w = $urandom_range(0, 1) ? $urandom : 32'd0;
    w[NCITY_W-1:0] = NCITY_W'(ncity);
    apb_write({REG_NUM_CITIES, 2'b00}, w);
    w = $urandom_range(0, 1) ? $urandom : 32'd0;
    w[CITY_W-1:0] = CITY_W'(origin);
    apb_write({REG_START_CITY, 2'b00}, w);
  endtask

  // edges touching the origin cost d, all others zero: large counts stay fast
  task automatic hub_phase(input int ncity, input int origin, input logic [15:0] d);
    int          n;
    logic [15:0] want;
    n = ncity > 16 ? 16 : (ncity == 0 ? 1 : ncity);
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++) begin
        want = (i == origin || j == origin) ? d : 16'd0;
        if (map_len[i][j] != want) begin
          if ($urandom_range(0, 1)) load_dist(i, j, want);
          else load_dist(j, i, want);
        end
      end
    set_cfg(ncity, origin);
    run_search();
  endtask

  task automatic roam_phase();
    int          ncity;
    int          n;
    int          origin;
    int          style;
    int          a;
    int          b;
    logic [15:0] d;
    ncity = $urandom_range(2, 7);
    if ($urandom_range(0, 9) == 0) ncity = $urandom_range(0, 1);
    n = ncity == 0 ? 1 : ncity;
    origin = ($urandom_range(0, 7) == 0) ? $urandom_range(n, 15) : $urandom_range(0, n - 1);
    style = $urandom_range(0, 2);
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if ($urandom_range(0, 9) < 8) begin
          if ($urandom_range(0, 4) == 0)
            load_dist($urandom_range(0, 15), $urandom_range(0, 15), 16'($urandom));
          case (style)
            0: d = 16'($urandom_range(0, 3));
            1: d = 16'($urandom);
            default: d = 16'($urandom_range(65000, 65535));
          endcase
          if ($urandom_range(0, 1)) load_dist(i, j, d);
          else load_dist(j, i, d);
        end
    set_cfg(ncity, origin);
    repeat ($urandom_range(1, 3)) begin
      run_search();
      if ($urandom_range(0, 2) == 0) wait_idle();
      if (n >= 2 && $urandom_range(0, 1)) begin
        a = $urandom_range(0, n - 1);
        b = (a + $urandom_range(1, n - 1)) % n;
        load_dist(a, b, 16'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int base;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero every off-diagonal entry of the table, then search with the reset configuration
    for (int i = 0; i < 16; i++)
      for (int j = i + 1; j < 16; j++) begin
        if ($urandom_range(0, 1)) load_dist(i, j, 16'd0);
        else load_dist(j, i, 16'd0);
      end
    run_search();

    set_cfg(2, 1);
    load_dist(1, 0, 16'hFFFF);
    run_search();
    load_dist(0, 0, 16'h1234);
    set_cfg(0, 0);
    run_search();
    set_cfg(1, 1);
    run_search();
    set_cfg(3, 2);
    load_dist(0, 1, 16'd5);
    load_dist(2, 0, 16'd5);
    load_dist(1, 2, 16'd5);
    run_search();
    set_cfg(3, 3);
    run_search();
    set_cfg(4, 0);
    load_dist(0, 1, 16'd10);
    load_dist(0, 2, 16'd1);
    load_dist(3, 0, 16'd7);
    load_dist(1, 2, 16'd3);
    load_dist(1, 3, 16'd2);
    load_dist(2, 3, 16'd9);
    run_search();

    base = words_sent;
    hub_phase(31, 15, 16'hFFFF);
    hub_phase(16, 0, 16'd0);
    while (words_sent - base < RANDOM_WORDS) begin
      if ($urandom_range(0, 4) == 0) calm_in = !calm_in;
      if ($urandom_range(0, 5) == 0)
        hub_phase($urandom_range(8, 31), $urandom_range(0, 15),
                  $urandom_range(0, 1) ? 16'($urandom) : 16'hFFFF);
      else
        roam_phase();
    end

    wait_idle();
    if (bad_words == 0)
      $display("shortest_route_branch_bound_tb: done, clean");
    else
      $display("shortest_route_branch_bound_tb: done, errors");
    $finish;
  end

endmodule

// ----- shortest_route_branch_bound.f -----
rtl/srbb_pkg.sv
rtl/srbb_ram.sv
rtl/srbb_find.sv
rtl/shortest_route_branch_bound.sv
rtl/srbb_checker.sv
tb/shortest_route_branch_bound_check.sv
tb/shortest_route_branch_bound_tb.sv
